// ===== src/brlp_pkg.sv =====
// ----------------------------------------------------------------------------
// brlp_pkg: shared types and constants of the block RMS level meter
// Widths, reset values, configuration register indexes and the back-end
// sequencer states.
// ----------------------------------------------------------------------------
package brlp_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MAG_W    = 32;
    localparam int SQ_W     = 64;
    localparam int SUM_W    = 53;
    localparam int SHIFT_W  = 5;
    localparam int SCALE_W  = 16;
    localparam int LEVEL_W  = 24;
    localparam int BRIGHT_W = 8;
    localparam int PROD_W   = LEVEL_W + BRIGHT_W;
    localparam int CFG_W    = 16;
    localparam int ITER_W   = 6;

    localparam int BLOCK_SAMPLES_DEF = 64;

    localparam logic [SHIFT_W-1:0]  SHIFT_RESET = SHIFT_W'(14);
    localparam logic [SCALE_W-1:0]  SCALE_RESET = SCALE_W'(1000);
    localparam logic [SUM_W-1:0]    SUM_MAX     = '1;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = LEVEL_W'(8388608);
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = BRIGHT_W'(255);

    localparam int DIV_STEPS   = SUM_W;
    localparam int ROOT_STEPS  = (SUM_W + 1) / 2;
    localparam int SCALE_STEPS = BRIGHT_W;

    typedef enum logic [0:0] {
        CFG_DOWNSCALE_SHIFT  = 1'b0,
        CFG_FULL_SCALE_LEVEL = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_ROOT,
        B_LEVEL,
        B_PREP,
        B_SCALE,
        B_HOLD
    } back_state_t;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic [LEVEL_W-1:0]  level;
    } result_t;

endpackage

// ===== src/brlp_front.sv =====
// ----------------------------------------------------------------------------
// brlp_front: sample intake and sum-of-squares accumulator
// Shifts and rectifies each sample, squares it, accumulates with saturation
// and hands a closed block (sum, count) to the queue.
// ----------------------------------------------------------------------------
module brlp_front
    import brlp_pkg::*;
#(
    parameter int  BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
    localparam int CNT_W         = $clog2(BLOCK_SAMPLES + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] in_sample,
    input  logic                in_last,
    input  logic [SHIFT_W-1:0]  shift,
    output logic                blk_valid,
    input  logic                blk_ready,
    output logic [SUM_W-1:0]    blk_sum,
    output logic [CNT_W-1:0]    blk_count
);

    logic               s1_valid_reg;
    logic [MAG_W-1:0]   s1_mag_reg;
    logic               s1_last_reg;
    logic               s2_valid_reg;
    logic [SQ_W-1:0]    s2_sq_reg;
    logic               s2_last_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [MAG_W-1:0]   raw_inv;
    logic [MAG_W-1:0]   mag_next;
    logic [SQ_W-1:0]    total;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   cnt_next;
    logic               close;
    logic               s2_advance;
    logic               s2_load;
    logic               in_accept;

    assign raw_inv  = ~in_sample;
    assign mag_next = in_sample[SAMPLE_W-1] ? MAG_W'((raw_inv >> shift) + MAG_W'(1))
                                            : (in_sample >> shift);

    assign total    = {{(SQ_W-SUM_W){1'b0}}, sum_reg} + s2_sq_reg;
    assign sum_next = (total > {{(SQ_W-SUM_W){1'b0}}, SUM_MAX}) ? SUM_MAX
                                                                 : total[SUM_W-1:0];
    assign cnt_next = cnt_reg + CNT_W'(1);
    assign close    = s2_last_reg || (cnt_next == CNT_W'(BLOCK_SAMPLES));

    assign blk_valid  = s2_valid_reg && close;
    assign blk_sum    = sum_next;
    assign blk_count  = cnt_next;

    assign s2_advance = s2_valid_reg && (!close || blk_ready);
    assign s2_load    = s1_valid_reg && (!s2_valid_reg || s2_advance);
    assign in_ready   = !s1_valid_reg || s2_load;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s2_load)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_advance)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_advance)
            begin
                if (close)
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mag_reg  <= mag_next;
            s1_last_reg <= in_last;
        end
        if (s2_load)
        begin
            s2_sq_reg   <= SQ_W'(s1_mag_reg) * SQ_W'(s1_mag_reg);
            s2_last_reg <= s1_last_reg;
        end
    end

endmodule

// ===== src/brlp_queue.sv =====
// ----------------------------------------------------------------------------
// brlp_queue: two-entry queue of closed blocks
// Decouples the accumulator from the divide and square-root sequencer.
// ----------------------------------------------------------------------------
module brlp_queue
    import brlp_pkg::*;
#(
    parameter int WIDTH = SUM_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/brlp_back.sv =====
// ----------------------------------------------------------------------------
// brlp_back: mean, square root and brightness sequencer
// Divides the block sum by its count one bit per cycle, takes the integer
// square root two bits per cycle, scales to brightness and holds the result.
// ----------------------------------------------------------------------------
module brlp_back
    import brlp_pkg::*;
#(
    parameter int  BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
    localparam int CNT_W         = $clog2(BLOCK_SAMPLES + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               blk_valid,
    output logic               blk_ready,
    input  logic [SUM_W-1:0]   blk_sum,
    input  logic [CNT_W-1:0]   blk_count,
    input  logic [SCALE_W-1:0] full_scale,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    localparam logic [SUM_W-1:0] ROOT_BIT0 = SUM_W'(1) << (2 * (ROOT_STEPS - 1));

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [ITER_W-1:0]    iter_reg;
    logic [SUM_W-1:0]     work_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     div_reg;
    logic [SUM_W-1:0]     root_reg;
    logic [SUM_W-1:0]     bit_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic                 sat_reg;
    logic [SCALE_W-1:0]   srem_reg;
    logic [BRIGHT_W-1:0]  qsh_reg;
    logic                 res_valid_reg;
    result_t              res_reg;

    logic                 out_free;
    logic                 div_last;
    logic                 root_last;
    logic                 scale_last;
    logic [CNT_W:0]       rem_sh;
    logic [CNT_W:0]       rem_diff;
    logic                 qbit;
    logic [SUM_W:0]       trial;
    logic                 root_take;
    logic [SUM_W:0]       work_diff;
    logic [PROD_W-1:0]    prod;
    logic [SCALE_W:0]     srem_sh;
    logic [SCALE_W:0]     srem_diff;
    logic                 sbit;
    logic [BRIGHT_W-1:0]  bright;

    assign out_free   = !res_valid_reg || res_ready;
    assign div_last   = (iter_reg == ITER_W'(DIV_STEPS - 1));
    assign root_last  = (iter_reg == ITER_W'(ROOT_STEPS - 1));
    assign scale_last = (iter_reg == ITER_W'(SCALE_STEPS - 1));

    assign rem_sh   = {rem_reg, work_reg[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign qbit     = (rem_sh >= {1'b0, div_reg});

    assign trial     = {1'b0, root_reg} + {1'b0, bit_reg};
    assign root_take = ({1'b0, work_reg} >= trial);
    assign work_diff = {1'b0, work_reg} - trial;

    assign prod = {level_reg, {BRIGHT_W{1'b0}}} - {{BRIGHT_W{1'b0}}, level_reg};

    assign srem_sh   = {srem_reg, qsh_reg[BRIGHT_W-1]};
    assign srem_diff = srem_sh - {1'b0, scale_reg};
    assign sbit      = (srem_sh >= {1'b0, scale_reg});

    assign bright = sat_reg ? '0 : (BRIGHT_MAX - qsh_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (blk_valid)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (div_last)
                begin
                    state_next = B_ROOT;
                end
            end
            B_ROOT:
            begin
                if (root_last)
                begin
                    state_next = B_LEVEL;
                end
            end
            B_LEVEL:
            begin
                state_next = B_PREP;
            end
            B_PREP:
            begin
                state_next = B_SCALE;
            end
            B_SCALE:
            begin
                if (scale_last)
                begin
                    state_next = B_HOLD;
                end
            end
            B_HOLD:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        blk_ready = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                blk_ready = 1'b1;
            end
            default:
            begin
                blk_ready = 1'b0;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            iter_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                iter_reg <= '0;
            end
            else
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end

            if ((state_reg == B_HOLD) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (blk_valid)
                begin
                    work_reg <= blk_sum;
                    rem_reg  <= '0;
                    div_reg  <= blk_count;
                end
            end
            B_DIV:
            begin
                rem_reg  <= qbit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                work_reg <= {work_reg[SUM_W-2:0], qbit};
                if (div_last)
                begin
                    root_reg <= '0;
                    bit_reg  <= ROOT_BIT0;
                end
            end
            B_ROOT:
            begin
                if (root_take)
                begin
                    work_reg <= work_diff[SUM_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            B_LEVEL:
            begin
                level_reg <= (root_reg > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                            : root_reg[LEVEL_W-1:0];
                scale_reg <= (full_scale == '0) ? SCALE_W'(1) : full_scale;
            end
            B_PREP:
            begin
                sat_reg  <= (level_reg >= LEVEL_W'(scale_reg));
                srem_reg <= prod[SCALE_W+BRIGHT_W-1:BRIGHT_W];
                qsh_reg  <= prod[BRIGHT_W-1:0];
            end
            B_SCALE:
            begin
                srem_reg <= sbit ? srem_diff[SCALE_W-1:0] : srem_sh[SCALE_W-1:0];
                qsh_reg  <= {qsh_reg[BRIGHT_W-2:0], sbit};
            end
            B_HOLD:
            begin
                if (out_free)
                begin
                    res_reg.level      <= level_reg;
                    res_reg.brightness <= bright;
                end
            end
            default:
            begin
                work_reg <= work_reg;
            end
        endcase
    end

endmodule

// ===== src/block_rms_level_to_pwm_top.sv =====
// Throughput: one sample per cycle into the accumulator unless the block queue is full;
// per block the back end runs 53 divide steps, 27 root steps, 8 scale steps and setup.
// A two-entry block queue lets sampling run on while the back end works.
// Reset: downscale_shift 14, full_scale_level 1000, sum, count, queue cleared.
// ----------------------------------------------------------------------------
// block_rms_level_to_pwm_top: block RMS level meter with brightness output
// Accumulates squared shifted sample magnitudes per block and reports the
// integer RMS level and an inverted 8-bit brightness.
// ----------------------------------------------------------------------------
module block_rms_level_to_pwm_top
    import brlp_pkg::*;
#(
    parameter int  BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
    localparam int CNT_W         = $clog2(BLOCK_SAMPLES + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [31:0] sample
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // [23:0] level, [31:24] brightness
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cfg_index_t          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    logic [SHIFT_W-1:0] shift_reg;
    logic [SCALE_W-1:0] full_scale_reg;

    logic               blk_valid;
    logic               blk_ready;
    logic [SUM_W-1:0]   blk_sum;
    logic [CNT_W-1:0]   blk_count;
    logic               q_valid;
    logic               q_ready;
    logic [SUM_W-1:0]   q_sum;
    logic [CNT_W-1:0]   q_count;
    result_t            res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= SHIFT_RESET;
            full_scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DOWNSCALE_SHIFT:
                begin
                    shift_reg <= cfg_data[SHIFT_W-1:0];
                end
                CFG_FULL_SCALE_LEVEL:
                begin
                    full_scale_reg <= cfg_data[SCALE_W-1:0];
                end
                default:
                begin
                    shift_reg <= shift_reg;
                end
            endcase
        end
    end

    brlp_front #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .shift     (shift_reg),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_sum   (blk_sum),
        .blk_count (blk_count)
    );

    brlp_queue #(
        .WIDTH (SUM_W + CNT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (blk_valid),
        .push_ready (blk_ready),
        .push_data  ({blk_count, blk_sum}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   ({q_count, q_sum})
    );

    brlp_back #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk_valid  (q_valid),
        .blk_ready  (q_ready),
        .blk_sum    (q_sum),
        .blk_count  (q_count),
        .full_scale (full_scale_reg),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = res;

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[LEVEL_W-1:0] <= LEVEL_MAX))
        else $error("level above saturation limit");

    a_bright_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (full_scale_reg != '0)
            && (m_axis_tdata[LEVEL_W-1:0] >= LEVEL_W'(full_scale_reg)))
        |-> (m_axis_tdata[PROD_W-1:LEVEL_W] == '0))
        else $error("brightness not zero at full scale");

    a_block_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_valid && !blk_ready) |=> blk_valid)
        else $error("closed block dropped while queue full");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid |-> (blk_count != '0))
        else $error("closed block with zero count");

endmodule
